@@ design/lsfx_pkg.sv @@
`default_nettype none
package lsfx_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned FrameW   = 11;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PIXEL_COUNT = 2'd0,
    REG_EFFECT_MODE = 2'd1,
    REG_BASE_COLOR  = 2'd2,
    REG_FILL_COUNT  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    MODE_FILL      = 3'd0,
    MODE_WIPE      = 3'd1,
    MODE_RAINBOW   = 3'd2,
    MODE_CYCLE     = 3'd3,
    MODE_CHASE     = 3'd4,
    MODE_CHASE_RB  = 3'd5,
    MODE_CLEAR     = 3'd6,
    MODE_SPARE     = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PAINT,
    ST_EMIT,
    ST_UNPAINT,
    ST_ZERO
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       clr_idx;    // restart pixel sweep at 0 (or at fill_len)
    logic       zero_from_fill; // sweep start is fill length
    logic       div_start;
    logic       paint_en;   // write computed color at idx (chase: chase position; fill/wipe: frame)
    logic       unpaint_en; // write zero on chase positions
    logic       zero_en;    // write zero at idx
    logic       emit_rd;    // issue a store read for emit
    logic       frame_clr;
    logic       frame_inc;
    logic       run_set;
    logic       run_clr;
    logic       last_set;
    logic       step_idx;
  } lsfx_cmd_t;

  typedef struct packed {
    logic idx_end;      // idx is the last pixel of the sweep
    logic div_done;
    logic running;
    logic frame_over;   // frame_number >= total
    logic frame_last;   // frame_number + 1 >= total
  } lsfx_sts_t;

  function automatic logic [ColorW-1:0] wheel(input logic [7:0] pos);
    logic [7:0] w;
    logic [7:0] w3;
    logic [ColorW-1:0] c;
    w = 8'd255 - pos;
    if (w < 8'd85) begin
      w3 = 8'(w * 8'd3);
      c = {8'd255 - w3, 8'd0, w3};
    end else if (w < 8'd170) begin
      w3 = 8'((w - 8'd85) * 8'd3);
      c = {8'd0, w3, 8'd255 - w3};
    end else begin
      w3 = 8'((w - 8'd170) * 8'd3);
      c = {w3, 8'd255 - w3, 8'd0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/lsfx_ram.sv @@
`default_nettype none
module lsfx_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(Depth)-1:0] waddr_i,
  input  wire  [Width-1:0]         wdata_i,
  input  wire  [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ design/lsfx_ctrl.sv @@
`default_nettype none
module lsfx_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 start_i,
  output logic                in_ready_o,
  input  wire  [2:0]          mode_i,
  input  wire                 out_free_i,
  input  wire                 out_busy_i,
  input  wire  lsfx_pkg::lsfx_sts_t sts_i,
  output lsfx_pkg::lsfx_cmd_t cmd_o
);
  import lsfx_pkg::*;

  state_e state_q, state_d;
  logic   rd_pend_q, rd_pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  logic is_fill, is_chase, is_clear;
  assign is_fill  = (mode_i == MODE_FILL);
  assign is_chase = (mode_i == MODE_CHASE) || (mode_i == MODE_CHASE_RB);
  assign is_clear = (mode_i == MODE_CLEAR) || (mode_i == MODE_SPARE);

  always_comb begin
    state_d    = state_q;
    rd_pend_d  = rd_pend_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_busy_i;
        if (in_valid_i && !out_busy_i) begin
          if (start_i) begin
            cmd_o.frame_clr = 1'b1;
            cmd_o.run_set   = 1'b1;
          end
          if (start_i || sts_i.running) begin
            if (is_clear) begin
              cmd_o.run_clr = 1'b1;
              if (start_i) begin
                cmd_o.clr_idx = 1'b1;
                state_d = ST_ZERO;
              end
            end else begin
              cmd_o.div_start = 1'b1;
              state_d = ST_DIV;
            end
          end
        end
      end
      // Frame counter now valid; decide over, and wait for the divider to finish.
      ST_DIV: begin
        if (sts_i.frame_over) begin
          cmd_o.run_clr = 1'b1;
          if (is_fill) begin
            cmd_o.clr_idx = 1'b1;
            cmd_o.zero_from_fill = 1'b1;
            state_d = ST_ZERO;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (sts_i.div_done) begin
          cmd_o.clr_idx = 1'b1;
          if (sts_i.frame_last) cmd_o.last_set = 1'b1;
          state_d = ST_PAINT;
        end
      end
      ST_PAINT: begin
        cmd_o.paint_en = 1'b1;
        cmd_o.step_idx = 1'b1;
        if (sts_i.idx_end) begin
          cmd_o.clr_idx = 1'b1;
          rd_pend_d = 1'b0;
          state_d = ST_EMIT;
        end
      end
      // A read is issued only when the output stage is free and no earlier read is still in flight.
      ST_EMIT: begin
        if (out_free_i && !rd_pend_q) begin
          cmd_o.emit_rd = 1'b1;
          cmd_o.step_idx = 1'b1;
          if (sts_i.idx_end) begin
            rd_pend_d = 1'b1;
          end
        end
        if (rd_pend_q && out_free_i) begin
          cmd_o.clr_idx = 1'b1;
          rd_pend_d = 1'b0;
          if (is_chase) begin
            state_d = ST_UNPAINT;
          end else begin
            cmd_o.frame_inc = 1'b1;
            if (sts_i.frame_last) begin
              cmd_o.run_clr = 1'b1;
              if (is_fill) begin
                cmd_o.zero_from_fill = 1'b1;
                state_d = ST_ZERO;
              end else begin
                state_d = ST_IDLE;
              end
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_UNPAINT: begin
        cmd_o.unpaint_en = 1'b1;
        cmd_o.step_idx = 1'b1;
        if (sts_i.idx_end) begin
          cmd_o.frame_inc = 1'b1;
          if (sts_i.frame_last) cmd_o.run_clr = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_ZERO: begin
        cmd_o.zero_en = 1'b1;
        cmd_o.step_idx = 1'b1;
        if (sts_i.idx_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ design/lsfx_dp.sv @@
`default_nettype none
module lsfx_dp #(
  parameter int unsigned MaxPixels = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [lsfx_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [lsfx_pkg::CfgDataW-1:0] cfg_data_i,
  output logic [2:0]           mode_o,
  input  wire  lsfx_pkg::lsfx_cmd_t cmd_i,
  output lsfx_pkg::lsfx_sts_t  sts_o,
  output logic                 out_free_o,
  output logic                 out_busy_o,
  output logic                 m_valid_o,
  input  wire                  m_ready_i,
  output logic [5:0]           m_index_o,
  output logic [lsfx_pkg::ColorW-1:0] m_color_o,
  output logic                 m_last_o,
  output logic                 m_done_o
);
  import lsfx_pkg::*;

  localparam int unsigned AW = $clog2(MaxPixels);
  localparam int unsigned NW = $clog2(MaxPixels + 1);

  // Configuration registers.
  logic [6:0]        pcount_q;
  logic [2:0]        mode_q;
  logic [ColorW-1:0] base_q;
  logic [7:0]        fcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= 7'd16;
      mode_q   <= MODE_FILL;
      base_q   <= '0;
      fcount_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PIXEL_COUNT: pcount_q <= cfg_data_i[6:0];
        REG_EFFECT_MODE: mode_q   <= cfg_data_i[2:0];
        REG_BASE_COLOR:  base_q   <= cfg_data_i[ColorW-1:0];
        REG_FILL_COUNT:  fcount_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end
  assign mode_o = mode_q;

  // Effective strip length and fill length.
  logic [NW-1:0] n;
  logic [NW-1:0] fill_len;
  always_comb begin
    if (pcount_q == 7'd0) n = NW'(1);
    else if ({1'b0, pcount_q} > 8'(MaxPixels)) n = NW'(MaxPixels);
    else n = NW'(pcount_q);
    fill_len = ({1'b0, fcount_q} < 9'(n)) ? NW'(fcount_q) : n;
  end

  logic [FrameW-1:0] total;
  always_comb begin
    unique case (mode_e'(mode_q))
      MODE_FILL:     total = FrameW'(fill_len);
      MODE_WIPE:     total = FrameW'(n);
      MODE_RAINBOW:  total = FrameW'(256);
      MODE_CYCLE:    total = FrameW'(1280);
      MODE_CHASE:    total = FrameW'(30);
      MODE_CHASE_RB: total = FrameW'(768);
      default:       total = '0;
    endcase
  end

  // Frame state.
  logic [FrameW-1:0] frame_q;
  logic              run_q, last_q;
  logic [9:0]        fj_q;   // frame / 3
  logic [1:0]        fq_q;   // frame % 3
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      run_q   <= 1'b0;
      last_q  <= 1'b0;
      fj_q    <= '0;
      fq_q    <= '0;
    end else begin
      if (cmd_i.frame_clr) begin
        frame_q <= '0;
        fj_q    <= '0;
        fq_q    <= '0;
      end else if (cmd_i.frame_inc) begin
        frame_q <= frame_q + FrameW'(1);
        if (fq_q == 2'd2) begin
          fq_q <= '0;
          fj_q <= fj_q + 10'd1;
        end else begin
          fq_q <= fq_q + 2'd1;
        end
      end
      // A start in clear mode both starts and ends the effect.
      if (cmd_i.run_clr) run_q <= 1'b0;
      else if (cmd_i.run_set) run_q <= 1'b1;
      if (cmd_i.div_start) last_q <= 1'b0;
      else if (cmd_i.last_set) last_q <= 1'b1;
    end
  end

  // Rainbow cycle spacing: step = 256/n, remainder kept for i*256/n by
  // accumulation. Restoring divider, one bit per cycle.
  logic [8:0]    dv_rem_q;
  logic [8:0]    dv_quo_q;
  logic [3:0]    dv_cnt_q;
  logic          dv_busy_q;
  logic [9:0]    dv_trial;
  always_comb dv_trial = {dv_rem_q, dv_quo_q[8]} - 10'(n);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_busy_q <= 1'b0;
      dv_cnt_q  <= '0;
      dv_rem_q  <= '0;
      dv_quo_q  <= '0;
    end else if (cmd_i.div_start) begin
      dv_busy_q <= 1'b1;
      dv_cnt_q  <= 4'd9;
      dv_rem_q  <= '0;
      dv_quo_q  <= 9'd256;
    end else if (dv_busy_q) begin
      if (!dv_trial[9]) begin
        dv_rem_q <= dv_trial[8:0];
        dv_quo_q <= {dv_quo_q[7:0], 1'b1};
      end else begin
        dv_rem_q <= {dv_rem_q[7:0], dv_quo_q[8]};
        dv_quo_q <= {dv_quo_q[7:0], 1'b0};
      end
      dv_cnt_q <= dv_cnt_q - 4'd1;
      if (dv_cnt_q == 4'd1) dv_busy_q <= 1'b0;
    end
  end

  // Pixel sweep index plus chase position and rainbow-cycle accumulators.
  logic [NW-1:0] idx_q;
  logic [NW-1:0] end_q;
  logic [8:0]    acc_q;   // floor(i*256/n)
  logic [NW-1:0] accr_q;  // remainder
  logic [NW-1:0] base_i_q; // chase base i
  logic          chase;
  assign chase = (mode_q == MODE_CHASE) || (mode_q == MODE_CHASE_RB);

  logic [NW:0] nxt_rem;
  logic [NW-1:0] chase_p;
  always_comb begin
    nxt_rem = {1'b0, accr_q} + (NW+1)'(dv_rem_q[NW-1:0]);
    chase_p = base_i_q + NW'(fq_q);
  end

  // (n-1)/3 as (x*171)>>9, exact for x below 256.
  logic [NW-1:0] sweep_end;
  always_comb begin
    sweep_end = n - NW'(1);
    if (chase && (cmd_i.paint_en || cmd_i.unpaint_en)) begin
      sweep_end = NW'((14'(n - NW'(1)) * 14'd171) >> 9);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_idx) begin
      idx_q    <= cmd_i.zero_from_fill ? fill_len : '0;
      acc_q    <= '0;
      accr_q   <= '0;
      base_i_q <= '0;
    end else if (cmd_i.step_idx) begin
      idx_q    <= idx_q + NW'(1);
      base_i_q <= base_i_q + NW'(3);
      if (nxt_rem >= (NW+1)'(n)) begin
        accr_q <= NW'(nxt_rem - (NW+1)'(n));
        acc_q  <= acc_q + dv_quo_q + 9'd1;
      end else begin
        accr_q <= NW'(nxt_rem);
        acc_q  <= acc_q + dv_quo_q;
      end
    end
  end

  // Zero sweep stops at n-1 (and is empty when start >= n).
  logic zero_end;
  assign zero_end = (idx_q + NW'(1) >= n) || (idx_q >= n);
  always_comb begin
    sts_o.idx_end = cmd_i.zero_en ? zero_end :
                    ((chase && (cmd_i.paint_en || cmd_i.unpaint_en)) ?
                      (idx_q >= sweep_end) : (idx_q == sweep_end));
    if (!chase && cmd_i.paint_en &&
        (mode_q == MODE_FILL || mode_q == MODE_WIPE)) begin
      sts_o.idx_end = 1'b1;
    end
    sts_o.div_done   = !dv_busy_q && !cmd_i.div_start;
    sts_o.running    = run_q;
    sts_o.frame_over = frame_q >= total;
    sts_o.frame_last = (12'(frame_q) + 12'd1) >= 12'(total);
  end

  // Color for paint.
  logic [ColorW-1:0] paint_c;
  logic [AW-1:0]     waddr;
  logic              we;
  logic [ColorW-1:0] wdata;
  logic [9:0]        crb;
  always_comb begin
    crb = 10'(base_i_q) + fj_q;
    if (crb >= 10'd255) crb = crb - 10'd255;
    unique case (mode_e'(mode_q))
      MODE_FILL, MODE_WIPE: paint_c = base_q;
      MODE_RAINBOW:  paint_c = wheel(8'(idx_q) + 8'(frame_q));
      MODE_CYCLE:    paint_c = wheel(acc_q[7:0] + 8'(frame_q));
      MODE_CHASE:    paint_c = base_q;
      default:       paint_c = wheel(crb[7:0]);
    endcase
    we    = 1'b0;
    wdata = '0;
    waddr = AW'(idx_q);
    if (cmd_i.paint_en) begin
      wdata = paint_c;
      if (chase) begin
        waddr = AW'(chase_p);
        we    = (chase_p < n);
      end else if (mode_q == MODE_FILL || mode_q == MODE_WIPE) begin
        waddr = AW'(frame_q);
        we    = (frame_q < FrameW'(MaxPixels));
      end else begin
        we = 1'b1;
      end
    end else if (cmd_i.unpaint_en) begin
      waddr = AW'(chase_p);
      we    = (chase_p < n);
    end else if (cmd_i.zero_en) begin
      we = (idx_q < n);
    end
  end

  logic [ColorW-1:0] rdata;
  lsfx_ram #(.Width(ColorW), .Depth(MaxPixels)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (AW'(idx_q)),
    .rdata_o (rdata)
  );

  // Written marks: an entry never written since reset reads as zero.
  logic [MaxPixels-1:0] wr_mark_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_mark_q <= '0;
    end else if (we) begin
      wr_mark_q[waddr] <= 1'b1;
    end
  end

  // Read tag stage, then output register.
  logic          rv_q;
  logic [5:0]    ridx_q;
  logic          rlast_q;
  logic          rmark_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= cmd_i.emit_rd;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_rd) begin
      ridx_q  <= 6'(idx_q);
      rlast_q <= (idx_q == n - NW'(1));
      rmark_q <= wr_mark_q[AW'(idx_q)];
    end
  end

  // Output register is free when no read is in flight and it is empty or taken
  // this cycle. A read lands only when free: emit_rd is issued only when free.
  assign out_free_o = !rv_q && (!m_valid_o || m_ready_i);
  assign out_busy_o = m_valid_o || rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_o <= 1'b0;
    end else if (rv_q) begin
      m_valid_o <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_o <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      m_index_o <= ridx_q;
      m_color_o <= rmark_q ? rdata : '0;
      m_last_o  <= rlast_q;
      m_done_o  <= last_q;
    end
  end
endmodule
`default_nettype wire

@@ design/led_strip_effect_generator.sv @@
`default_nettype none
// LED strip effect generator.
// Input stream: one item per frame tick; tdata[0] = start_req (1 restarts the
// selected effect, 0 advances one frame). Output stream: one item per pixel,
// pixels 0..n-1 in strip order, tlast on the last pixel of the frame.
// Configuration: cfg_we_i writes register cfg_idx_i (0 pixel_count,
// 1 effect_mode, 2 base_color, 3 fill_count); write only while idle.
// Sequence: a tick is taken only when idle with the output empty. Frame setup
// runs a bit-serial 256/n divider after the accept, then decides whether the
// effect is over; then the store is painted: every pixel for rainbow modes,
// ceil(n/3) positions for chase, one pixel for fill and wipe. Emission reads
// the store then loads the output register for each pixel, with one read in
// flight at a time; chase then blanks its pixels. A start in clear mode
// zeroes the store, the end of fill zeroes pixels F..n-1. If the receiver
// stalls, emission holds on the output register; nothing is lost. Reset
// restores the register defaults, stops the effect and makes every store
// entry read as zero.
module led_strip_effect_generator #(
  parameter int unsigned MAX_PIXELS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [0] start_req
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [5:0] pixel_index, [29:6] pixel_color
  output logic        m_axis_tlast,   // last_pixel
  output logic        m_axis_tuser,   // effect_done
  input  wire         cfg_we_i,
  input  wire  [lsfx_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [lsfx_pkg::CfgDataW-1:0] cfg_data_i
);
  import lsfx_pkg::*;

  lsfx_cmd_t         cmd;
  lsfx_sts_t         sts;
  logic [2:0]        mode;
  logic              out_free, out_busy;
  logic [5:0]        idx;
  logic [ColorW-1:0] color;

  lsfx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .start_i    (s_axis_tdata[0]),
    .in_ready_o (s_axis_tready),
    .mode_i     (mode),
    .out_free_i (out_free),
    .out_busy_i (out_busy),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsfx_dp #(.MaxPixels(MAX_PIXELS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .mode_o     (mode),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_free_o (out_free),
    .out_busy_o (out_busy),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_index_o  (idx),
    .m_color_o  (color),
    .m_last_o   (m_axis_tlast),
    .m_done_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, color, idx};
endmodule
`default_nettype wire
